// ===== hdl/bpr_pkg.sv =====
// Shared types and codes of the BMP pixel row converter.
package bpr_pkg;

  // Action codes of an input item.
  localparam logic [1:0] ACT_PAL_WRITE = 2'd0;
  localparam logic [1:0] ACT_PIXEL     = 2'd1;
  localparam logic [1:0] ACT_NEW_IMAGE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;
  localparam logic [1:0] REG_WIDE   = 2'd3;

  // Entries of the job queue between front and back.
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [10:0] column;
    logic [10:0] row;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [2:0]  bytes_per_pixel;
    logic        wide_output;
  } cfg_t;

  // One unit of work for the back end: a palette write or a finished pixel.
  typedef struct packed {
    logic        is_pal;
    logic [7:0]  index;
    logic [23:0] color;
    logic [10:0] column;
    logic [10:0] row;
    logic        last;
    logic [2:0]  bpp;
  } job_t;

endpackage

// ===== hdl/bpr_front.sv =====
// Front end: accepts items, assembles pixels, tracks columns, rows and padding.
module bpr_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpr_pkg::cfg_t     cfg_i,
  input  logic              accept_i,
  input  bpr_pkg::in_item_t item_i,
  output logic              push_o,
  output bpr_pkg::job_t     job_o
);
  import bpr_pkg::*;

  logic [23:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  logic [11:0] col_q, col_d;
  logic [11:0] rows_q, rows_d;
  logic [1:0]  pad_q, pad_d;
  logic        done_q, done_d;

  logic [11:0] w, h;
  logic [2:0]  bpp;
  logic [23:0] acc;
  logic [2:0]  wb;
  logic [11:0] row_full;

  // Effective register values.
  always_comb begin
    if (cfg_i.image_width == 12'd0) w = 12'd1;
    else if (32'(cfg_i.image_width) > MAX_WIDTH) w = 12'(MAX_WIDTH);
    else w = cfg_i.image_width;
    if (cfg_i.image_height == 12'd0) h = 12'd1;
    else if (32'(cfg_i.image_height) > MAX_HEIGHT) h = 12'(MAX_HEIGHT);
    else h = cfg_i.image_height;
    if (cfg_i.bytes_per_pixel == 3'd0) bpp = 3'd1;
    else if (cfg_i.bytes_per_pixel > 3'd4) bpp = 3'd4;
    else bpp = cfg_i.bytes_per_pixel;
  end

  always_comb begin
    acc_d  = acc_q;
    pos_d  = pos_q;
    col_d  = col_q;
    rows_d = rows_q;
    pad_d  = pad_q;
    done_d = done_q;
    push_o = 1'b0;
    job_o  = '0;
    acc    = acc_q;
    wb     = 3'(w[1:0]) * bpp;
    row_full = h - 12'd1 - rows_q;
    if (accept_i) begin
      unique case (item_i.action)
        ACT_PAL_WRITE: begin
          push_o       = 1'b1;
          job_o.is_pal = 1'b1;
          job_o.index  = item_i.palette_index;
          job_o.color  = item_i.palette_color;
        end
        ACT_NEW_IMAGE: begin
          acc_d  = '0;
          pos_d  = '0;
          col_d  = '0;
          rows_d = '0;
          pad_d  = '0;
          done_d = 1'b0;
        end
        ACT_PIXEL: begin
          if (!(done_q || rows_q >= h)) begin
            if (pad_q != 2'd0) begin
              pad_d = pad_q - 2'd1;
            end else begin
              if (pos_q != 2'd3) acc = acc_q | (24'(item_i.data_byte) << {pos_q, 3'b000});
              if ({1'b0, pos_q} + 3'd1 < bpp) begin
                acc_d = acc;
                pos_d = pos_q + 2'd1;
              end else begin
                push_o       = 1'b1;
                job_o.color  = acc;
                job_o.index  = acc[7:0];
                job_o.column = col_q[10:0];
                job_o.row    = row_full[10:0];
                job_o.bpp    = bpp;
                acc_d = '0;
                pos_d = '0;
                if ({1'b0, col_q} + 13'd1 >= {1'b0, w}) begin
                  col_d  = '0;
                  pad_d  = 2'(3'd0 - wb);
                  rows_d = rows_q + 12'd1;
                  if (rows_d >= h) begin
                    done_d     = 1'b1;
                    job_o.last = 1'b1;
                  end
                end else begin
                  col_d = col_q + 12'd1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= '0;
      col_q  <= '0;
      rows_q <= '0;
      pad_q  <= '0;
      done_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      col_q  <= col_d;
      rows_q <= rows_d;
      pad_q  <= pad_d;
      done_q <= done_d;
    end
  end

endmodule

// ===== hdl/bpr_queue.sv =====
// Short job queue that decouples the front end from the back end.
module bpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bpr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bpr_pkg::job_t head_o
);
  import bpr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

endmodule

// ===== hdl/bpr_back.sv =====
// Back end: palette memory, color conversion and the output register.
module bpr_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpr_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  bpr_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpr_pkg::out_item_t out_item_o
);
  import bpr_pkg::*;

  localparam int unsigned AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] rd_q;
  job_t        s1_q;
  logic        s1_valid_q, s1_valid_d;
  logic        s1_hit_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q;
  logic        out_ready, s1_take, head_hit;
  logic [23:0] color;
  logic [15:0] value;

  function automatic logic [15:0] to_rgb332(logic [23:0] c);
    return {8'd0, c[23:21], c[15:13], c[7:6]};
  endfunction

  function automatic logic [15:0] to_rgb565(logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [15:0] rgb565_to_rgb332(logic [15:0] c);
    return {8'd0, c[15:13], c[10:8], c[4:3]};
  endfunction

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_take   = out_ready || !s1_valid_q;
  assign pop_o     = q_valid_i && (head_i.is_pal || s1_take);
  assign head_hit  = (32'(head_i.index) < PALETTE_ENTRIES);

  always_comb begin
    s1_valid_d  = s1_take ? (pop_o && !head_i.is_pal) : s1_valid_q;
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  // Conversion of the job held in stage one.
  always_comb begin
    if (s1_q.bpp == 3'd1) color = s1_hit_q ? rd_q : 24'd0;
    else color = s1_q.color;
    if (s1_q.bpp == 3'd2)
      value = cfg_i.wide_output ? color[15:0] : rgb565_to_rgb332(color[15:0]);
    else
      value = cfg_i.wide_output ? to_rgb565(color) : to_rgb332(color);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.is_pal && head_hit) pal_mem[AddrW'(head_i.index)] <= head_i.color;
    if (s1_take && pop_o && !head_i.is_pal) begin
      rd_q     <= pal_mem[AddrW'(head_i.index)];
      s1_q     <= head_i;
      s1_hit_q <= head_hit;
    end
    if (out_ready && s1_valid_q) begin
      out_q.pixel_value <= value;
      out_q.column      <= s1_q.column;
      out_q.row         <= s1_q.row;
      out_q.last_pixel  <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/bmp_pixel_row_converter_unit.sv =====
// Top level of the BMP pixel row converter: config registers and the three stages.
// Takes BMP pixel-data bytes in file order and gives one converted pixel
// (RGB332 in the low byte, or RGB565 in wide mode) with its display column,
// flipped display row and a last-pixel mark for each completed pixel; pad
// bytes, bytes after the last pixel and palette writes give no result.
// One input item is taken every cycle while the job queue has room. A
// pixel result leaves the output register after the item that completes
// it has passed the job queue hop, the palette read and the conversion
// register. The four-item job queue lets the input side keep accepting
// while a result waits at the output; the input stalls only once that
// queue is full. Palette writes travel through the same queue, so a pixel
// always sees every palette write accepted before it. Registers sit at byte
// addresses 0, 4, 8, 12 (width, height, bytes per pixel, wide mode); the user
// must write them only while no item is in flight, not enforced by the block.
module bmp_pixel_row_converter_unit #(
  parameter int unsigned MAX_WIDTH       = 2048,
  parameter int unsigned MAX_HEIGHT      = 2048,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bpr_pkg::in_item_t  in_item_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpr_pkg::out_item_t out_item_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bpr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_we;
  logic in_accept;
  logic push, q_full, q_valid, pop;
  job_t job, head;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_d.image_width     = pwdata[11:0];
        REG_HEIGHT: cfg_d.image_height    = pwdata[11:0];
        REG_BPP:    cfg_d.bytes_per_pixel = pwdata[2:0];
        REG_WIDE:   cfg_d.wide_output     = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg_q.image_width);
      REG_HEIGHT: prdata = 32'(cfg_q.image_height);
      REG_BPP:    prdata = 32'(cfg_q.bytes_per_pixel);
      REG_WIDE:   prdata = 32'(cfg_q.wide_output);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width     <= 12'd1;
      cfg_q.image_height    <= 12'd1;
      cfg_q.bytes_per_pixel <= 3'd3;
      cfg_q.wide_output     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // An item is taken whenever the job queue has room.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  bpr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(in_accept),
    .item_i  (in_item_i),
    .push_o  (push),
    .job_o   (job)
  );

  bpr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (head)
  );

  bpr_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // The front end never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // The queue is never popped while empty.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("job popped from empty queue");

  // The last pixel of an image lies on the top display row.
  a_last_on_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_pixel |-> out_item_o.row == 11'd0)
    else $error("last pixel not on row zero");

  // Narrow mode leaves the high byte of a result clear.
  a_narrow_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cfg_q.wide_output |-> out_item_o.pixel_value[15:8] == 8'd0)
    else $error("RGB332 result with high byte set");

endmodule
